// File: rtl/core/ohs_pkg.sv
// ----------------------------------------------------------------------------
// ohs_pkg
// Shared constants, codes and types of the open-addressing hash set.
// ----------------------------------------------------------------------------
package ohs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LG_MAX      = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int LGE_W       = $clog2(LG_MAX + 1);
  localparam int KEY_W       = 64;
  localparam int HASH_W      = 32;
  localparam int LG_W        = 4;
  localparam int LIVE_W      = 11;
  localparam int LIVE_MAX    = (1 << LIVE_W) - 1;
  localparam logic [LG_W-1:0] LG_RESET = 4'd10;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_INSERTED    = 3'd0,
    OUT_PRESENT     = 3'd1,
    OUT_FULL        = 3'd2,
    OUT_REMOVED     = 3'd3,
    OUT_REMOVE_MISS = 3'd4,
    OUT_FOUND       = 3'd5,
    OUT_ABSENT      = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_t;

  typedef struct packed {
    logic             occupied;
    logic             tombstone;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    outcome_t          outcome;
    logic [LIVE_W-1:0] live;
  } result_t;

endpackage

// File: rtl/core/ohs_slot_ram.sv
// ----------------------------------------------------------------------------
// ohs_slot_ram
// Slot store: key plus occupied and tombstone marks, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module ohs_slot_ram (
  input  logic             clk,
  input  ohs_pkg::ram_req_t req,
  output ohs_pkg::slot_t   rd_data
);

  ohs_pkg::slot_t mem [ohs_pkg::TABLE_DEPTH];
  ohs_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/ohs_probe_ctrl.sv
// ----------------------------------------------------------------------------
// ohs_probe_ctrl
// Sequencer: clears the marks after reset, then walks the probe sequence of
// each item one slot per cycle and writes back the modified slot.
// ----------------------------------------------------------------------------
module ohs_probe_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [ohs_pkg::KEY_W-1:0]   in_element_key,
  input  logic [ohs_pkg::HASH_W-1:0]  in_hash_value,
  input  logic [ohs_pkg::LG_W-1:0]    bucket_count_log2,
  input  logic                        out_free,
  input  ohs_pkg::slot_t              rd_data,
  output ohs_pkg::ram_req_t           ram_req,
  output ohs_pkg::result_t            res
);

  ohs_pkg::state_t                state_r, state_nxt;
  logic [ohs_pkg::IDX_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [1:0]                     cmd_r, cmd_nxt;
  logic [ohs_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [ohs_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [ohs_pkg::CNT_W-1:0]      probe_cnt_r, probe_cnt_nxt;
  logic                           tomb_seen_r, tomb_seen_nxt;
  logic [ohs_pkg::IDX_W-1:0]      tomb_idx_r, tomb_idx_nxt;
  logic [ohs_pkg::CNT_W-1:0]      live_r, live_nxt;

  logic [ohs_pkg::LGE_W-1:0]      lg_eff;
  logic [ohs_pkg::CNT_W-1:0]      n_buckets;
  logic [ohs_pkg::IDX_W-1:0]      mask;
  logic [ohs_pkg::IDX_W-1:0]      idx_step;
  logic [ohs_pkg::IDX_W-1:0]      tomb_pick;
  logic                           slot_empty;
  logic                           slot_hit;
  logic                           last_probe;
  logic                           fin;
  logic                           do_wr;
  logic [ohs_pkg::IDX_W-1:0]      wr_addr;
  ohs_pkg::slot_t                 wr_slot;
  ohs_pkg::outcome_t              outc;
  logic [ohs_pkg::CNT_W-1:0]      live_calc;

  always_comb begin
    if (int'(bucket_count_log2) > ohs_pkg::LG_MAX) begin
      lg_eff = ohs_pkg::LGE_W'(ohs_pkg::LG_MAX);
    end else begin
      lg_eff = ohs_pkg::LGE_W'(bucket_count_log2);
    end
  end

  assign n_buckets  = ohs_pkg::CNT_W'(1) << lg_eff;
  assign mask       = ohs_pkg::IDX_W'(n_buckets - ohs_pkg::CNT_W'(1));
  assign idx_step   = (idx_r + ohs_pkg::IDX_W'(1)) & mask;
  assign tomb_pick  = tomb_seen_r ? tomb_idx_r : idx_r;
  assign slot_empty = !rd_data.occupied && !rd_data.tombstone;
  assign slot_hit   = rd_data.occupied && !rd_data.tombstone && (rd_data.key == key_r);
  assign last_probe = (probe_cnt_r + ohs_pkg::CNT_W'(1)) == n_buckets;

  // probe decision for the slot now on the read port
  always_comb begin
    fin           = 1'b0;
    do_wr         = 1'b0;
    wr_addr       = idx_r;
    wr_slot       = '0;
    outc          = ohs_pkg::OUT_ABSENT;
    live_calc     = live_r;
    tomb_seen_nxt = tomb_seen_r;
    tomb_idx_nxt  = tomb_idx_r;
    case (cmd_r)
      ohs_pkg::CMD_INSERT: begin
        wr_slot.occupied = 1'b1;
        wr_slot.key      = key_r;
        if (slot_empty) begin
          fin       = 1'b1;
          do_wr     = 1'b1;
          wr_addr   = tomb_pick;
          outc      = ohs_pkg::OUT_INSERTED;
        end else if (rd_data.tombstone) begin
          if (!tomb_seen_r) begin
            tomb_seen_nxt = 1'b1;
            tomb_idx_nxt  = idx_r;
          end
          if (last_probe) begin
            fin     = 1'b1;
            do_wr   = 1'b1;
            wr_addr = tomb_pick;
            outc    = ohs_pkg::OUT_INSERTED;
          end
        end else if (rd_data.key == key_r) begin
          fin  = 1'b1;
          outc = ohs_pkg::OUT_PRESENT;
        end else if (last_probe) begin
          fin = 1'b1;
          if (tomb_seen_r) begin
            do_wr   = 1'b1;
            wr_addr = tomb_idx_r;
            outc    = ohs_pkg::OUT_INSERTED;
          end else begin
            outc = ohs_pkg::OUT_FULL;
          end
        end
        if (do_wr) begin
          live_calc = live_r + ohs_pkg::CNT_W'(1);
        end
      end
      ohs_pkg::CMD_REMOVE: begin
        wr_slot.tombstone = 1'b1;
        wr_slot.key       = rd_data.key;
        if (slot_hit) begin
          fin   = 1'b1;
          do_wr = 1'b1;
          outc  = ohs_pkg::OUT_REMOVED;
          if (live_r != '0) begin
            live_calc = live_r - ohs_pkg::CNT_W'(1);
          end
        end else if (slot_empty || last_probe) begin
          fin  = 1'b1;
          outc = ohs_pkg::OUT_REMOVE_MISS;
        end
      end
      ohs_pkg::CMD_CONTAINS: begin
        if (slot_hit) begin
          fin  = 1'b1;
          outc = ohs_pkg::OUT_FOUND;
        end else if (slot_empty || last_probe) begin
          fin  = 1'b1;
          outc = ohs_pkg::OUT_ABSENT;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    probe_cnt_nxt  = probe_cnt_r;
    live_nxt       = live_r;
    in_stall       = 1'b1;
    ram_req        = '0;
    ram_req.rd_addr = idx_r;
    res            = '0;
    case (state_r)
      ohs_pkg::ST_CLEAR: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = clr_addr_r;
        clr_addr_nxt    = clr_addr_r + ohs_pkg::IDX_W'(1);
        if (clr_addr_r == ohs_pkg::IDX_W'(ohs_pkg::TABLE_DEPTH - 1)) begin
          state_nxt = ohs_pkg::ST_IDLE;
        end
      end
      ohs_pkg::ST_IDLE: begin
        in_stall        = 1'b0;
        ram_req.rd_addr = in_hash_value[ohs_pkg::IDX_W-1:0] & mask;
        if (in_valid) begin
          cmd_nxt       = in_command;
          key_nxt       = in_element_key;
          idx_nxt       = in_hash_value[ohs_pkg::IDX_W-1:0] & mask;
          probe_cnt_nxt = '0;
          state_nxt     = ohs_pkg::ST_PROBE;
        end
      end
      ohs_pkg::ST_PROBE: begin
        if (fin) begin
          if (out_free) begin
            ram_req.wr_en   = do_wr;
            ram_req.wr_addr = wr_addr;
            ram_req.wr_data = wr_slot;
            live_nxt        = live_calc;
            res.valid       = 1'b1;
            res.outcome     = outc;
            if (int'(live_calc) > ohs_pkg::LIVE_MAX) begin
              res.live = ohs_pkg::LIVE_W'(ohs_pkg::LIVE_MAX);
            end else begin
              res.live = ohs_pkg::LIVE_W'(live_calc);
            end
            state_nxt = ohs_pkg::ST_IDLE;
          end
        end else begin
          idx_nxt         = idx_step;
          probe_cnt_nxt   = probe_cnt_r + ohs_pkg::CNT_W'(1);
          ram_req.rd_addr = idx_step;
        end
      end
      default: begin
        state_nxt = ohs_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ohs_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      live_r      <= '0;
      tomb_seen_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      live_r      <= live_nxt;
      tomb_seen_r <= (state_r == ohs_pkg::ST_PROBE) ? tomb_seen_nxt : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    probe_cnt_r <= probe_cnt_nxt;
    tomb_idx_r  <= tomb_idx_nxt;
  end

endmodule

// File: rtl/core/open_addressing_hash_set_core.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_set_core
// Set of 64-bit keys, linear probing with tombstones, one slot per cycle.
//
// Input channel (in_valid / in_stall): command, key and an external 32-bit
// hash. Result channel (out_valid / out_stall): outcome code and live count.
// Config channel (cfg_valid / cfg_ready): bucket_count_log2, write only while
// idle; ready is always high.
// After reset the slot marks are cleared in a pass over all 1024 slots during
// which in_stall stays high. An item probes 1 to the bucket count slots, then
// its result goes to the output register and the sequencer returns to idle;
// only then is the next item taken, as the slot memory has a single read
// port. An unused command ends on its first probe.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls and the next item finishes, the sequencer
// holds that item's last probe step until the register frees.
// ----------------------------------------------------------------------------
module open_addressing_hash_set_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [ohs_pkg::KEY_W-1:0]   in_element_key,
  input  logic [ohs_pkg::HASH_W-1:0]  in_hash_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_outcome,
  output logic [ohs_pkg::LIVE_W-1:0]  out_live_entries,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ohs_pkg::LG_W-1:0]    cfg_bucket_count_log2
);

  logic [ohs_pkg::LG_W-1:0]   bucket_log2_r;
  logic                       out_valid_r, out_valid_nxt;
  ohs_pkg::outcome_t          out_outcome_r;
  logic [ohs_pkg::LIVE_W-1:0] out_live_r;
  logic                       out_free;
  ohs_pkg::ram_req_t          ram_req;
  ohs_pkg::slot_t             rd_data;
  ohs_pkg::result_t           res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  ohs_slot_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  ohs_probe_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_element_key    (in_element_key),
    .in_hash_value     (in_hash_value),
    .bucket_count_log2 (bucket_log2_r),
    .out_free          (out_free),
    .rd_data           (rd_data),
    .ram_req           (ram_req),
    .res               (res)
  );

  always_comb begin
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_log2_r <= ohs_pkg::LG_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bucket_log2_r <= cfg_bucket_count_log2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_outcome_r <= res.outcome;
      out_live_r    <= res.live;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_live_entries = out_live_r;

  // a finished item never overwrites a result still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result produced while output register is held");

  // slot memory is never written in a cycle that accepts an item
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> in_stall)
    else $error("slot write while input is open");

  // an item's result never appears in the cycle it is accepted
  a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !res.valid)
    else $error("result in accept cycle");

  // a finished result is on the output in the next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> (out_valid && out_live_entries == $past(res.live)))
    else $error("result not registered");

endmodule
